// ===== rtl/acct_pkg.sv =====
// Package for the accounting record encoder: constants and types.
`timescale 1ns / 1ps
package acct_pkg;
  localparam int unsigned MantBits = 13;
  localparam int unsigned ExpBits  = 3;
  localparam logic [12:0] MantMax  = 13'h1fff;
  localparam logic [4:0]  FlagNoExec   = 5'h01;
  localparam logic [4:0]  FlagSignaled = 5'h10;
  localparam logic [6:0]  SignalMask   = 7'h7f;
  localparam logic [6:0]  TickHz       = 7'd100;
  localparam logic [0:0]  RegEnable    = 1'b0;
  // ceil(2^34 / 10000), exact for any 20-bit microseconds value
  localparam logic [20:0] UsecRecip    = 21'd1717987;
  // 2^24 = 167772 * 100 + 16
  localparam logic [17:0] HiQuot       = 18'd167772;
  // ceil(2^32 / 25), exact for operands below 2^27
  localparam logic [27:0] Recip25      = 28'd171798692;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_CODE,
    ST_FLOAT,
    ST_DONE
  } state_e;
endpackage

// ===== rtl/acct_record_field_encoder.sv =====
// Top level: process accounting record field encoder with shared comp_t unit.
// Sequence from input accept to result valid: prep step, reciprocal divide of elapsed
// by 100, 5 passes of the shared comp_t encoder, float step, then the registered output.
// Input is taken only while idle; with accounting disabled an item skips to the output step.
// A result not yet taken holds the sequencer in its last step; input waits meanwhile.
// Reset (rst_ni low, async): sequencer idle, no result pending, enable cleared.
`timescale 1ns / 1ps
module acct_record_field_encoder import acct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [47:0] now_ticks_i,
  input  logic [47:0] start_ticks_i,
  input  logic [31:0] wall_seconds_i,
  input  logic [31:0] user_seconds_i,
  input  logic [19:0] user_microseconds_i,
  input  logic [31:0] system_seconds_i,
  input  logic [19:0] system_microseconds_i,
  input  logic [31:0] peak_resident_kb_i,
  input  logic [31:0] minor_fault_count_i,
  input  logic [31:0] major_fault_count_i,
  input  logic [15:0] exit_status_i,
  input  logic        did_exec_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        record_valid_o,
  output logic [31:0] elapsed_float_bits_o,
  output logic [31:0] begin_seconds_o,
  output logic [15:0] user_time_code_o,
  output logic [15:0] system_time_code_o,
  output logic [15:0] memory_code_o,
  output logic [15:0] minor_fault_code_o,
  output logic [15:0] major_fault_code_o,
  output logic [4:0]  record_flags_o
);

  state_e state_q, state_d;
  logic        en_q;
  logic        en_item_q;
  logic        ovalid_q;
  logic        cnt_q, cnt_d;
  logic [2:0]  sel_q, sel_d;
  logic [47:0] el_q;
  logic [31:0] quo_q;
  logic [26:0] lox_q;
  logic [22:0] qlo_q;
  logic [31:0] wall_q;
  logic [38:0] ut_q, st_q;
  logic [31:0] mem_q, minf_q, majf_q;
  logic [19:0] uus_q, sus_q;
  logic [4:0]  flags_q;
  logic [15:0] codes_q [5];
  logic [31:0] fbits_q;

  // Write and read of the enable register
  assign pready = 1'b1;
  assign prdata = {31'd0, en_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == RegEnable) begin
      en_q <= pwdata[0];
    end
  end

  wire in_acc   = in_valid_i && in_ready_o;
  wire out_acc  = out_valid_o && out_ready_i;
  wire out_load = !ovalid_q || out_acc;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = en_q ? ST_PREP : ST_DONE;
      ST_PREP:  state_d = ST_DIV;
      ST_DIV:   if (cnt_q) state_d = ST_CODE;
      ST_CODE:  if (sel_q == 3'd4) state_d = ST_FLOAT;
      ST_FLOAT: state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Counters
  always_comb begin
    cnt_d = cnt_q;
    sel_d = sel_q;
    case (state_q)
      ST_PREP: cnt_d = 1'b0;
      ST_DIV:  begin
        cnt_d = 1'b1;
        sel_d = '0;
      end
      ST_CODE: sel_d = sel_q + 3'd1;
      default: ;
    endcase
  end

  // usec/10000 via restoring-free reciprocal: small enough for a table-free mult
  function automatic logic [6:0] usec_div(input logic [19:0] u);
    logic [40:0] p;
    logic [6:0] q;
    begin
      p = 41'(u) * 41'(UsecRecip);  // 2^34/10000 rounded up
      q = p[40:34];
      usec_div = q;
    end
  endfunction

  // Shared comp_t encoder
  logic [38:0] cin;
  logic [15:0] cout;
  always_comb begin
    case (sel_q)
      3'd0:    cin = ut_q;
      3'd1:    cin = st_q;
      3'd2:    cin = 39'(mem_q);
      3'd3:    cin = 39'(minf_q);
      default: cin = 39'(majf_q);
    endcase
  end
  always_comb begin
    logic [38:0] vp;
    logic [38:0] v;
    logic [3:0]  e;
    logic [5:0]  sh;
    logic        up;
    e  = '0;
    sh = '0;
    // shift count found from parallel compares; a 39-bit value needs at most 9
    for (int k = 0; k < 9; k++) begin
      if ((cin >> (ExpBits * k)) > 39'(MantMax)) begin
        e  = 4'(k + 1);
        sh = 6'(ExpBits * k);
      end
    end
    vp = cin >> sh;
    up = (e != 4'd0) && vp[2];
    v  = (e != 4'd0) ? (vp >> ExpBits) : cin;
    if (up) begin
      v = v + 39'd1;
      if (v > 39'(MantMax)) begin
        v = v >> ExpBits;
        e = e + 4'd1;
      end
    end
    if (e > 4'd7) cout = {3'd0, MantMax};
    else cout = {e[2:0], v[12:0]};
  end

  // Float conversion of elapsed (48-bit) with RNE
  logic [31:0] fcomb;
  always_comb begin
    logic [5:0]  msb;
    logic [47:0] sh;
    logic [24:0] m;
    logic        g, s;
    logic [7:0]  ex;
    msb = '0;
    for (int i = 0; i < 48; i++) if (el_q[i]) msb = 6'(i);
    sh = el_q << (6'd47 - msb);
    m = {1'b0, sh[47:24]};
    g = sh[23];
    s = |sh[22:0];
    if (g && (s || m[0])) m = m + 25'd1;
    ex = 8'd127 + 8'(msb);
    if (m[24]) begin
      ex = ex + 8'd1;
      m = m >> 1;
    end
    fcomb = (el_q == '0) ? 32'd0 : {1'b0, ex, m[22:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      cnt_q    <= 1'b0;
      sel_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      if (state_q == ST_DONE && out_load) ovalid_q <= 1'b1;
      else if (out_acc) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_acc) begin
        el_q    <= (now_ticks_i > start_ticks_i) ? now_ticks_i - start_ticks_i : '0;
        wall_q  <= wall_seconds_i;
        ut_q    <= 39'(user_seconds_i) * 39'(TickHz);
        st_q    <= 39'(system_seconds_i) * 39'(TickHz);
        uus_q   <= user_microseconds_i;
        sus_q   <= system_microseconds_i;
        mem_q   <= peak_resident_kb_i;
        minf_q  <= minor_fault_count_i;
        majf_q  <= major_fault_count_i;
        flags_q <= (did_exec_i ? 5'd0 : FlagNoExec) |
                   (((exit_status_i[6:0] & SignalMask) != 7'd0) ? FlagSignaled : 5'd0);
        en_item_q <= en_q;
      end
      ST_PREP: begin
        ut_q  <= ut_q + 39'(usec_div(uus_q));
        st_q  <= st_q + 39'(usec_div(sus_q));
        // elapsed/100 = hi*167772 + (16*hi + lo)/100, with hi, lo the 24-bit halves
        quo_q <= 32'(42'(el_q[47:24]) * 42'(HiQuot));
        lox_q <= 27'(({1'b0, el_q[47:24], 4'd0} + 29'(el_q[23:0])) >> 2);
      end
      ST_DIV: begin
        if (!cnt_q) qlo_q <= 23'((55'(lox_q) * 55'(Recip25)) >> 32);
        else quo_q <= quo_q + 32'(qlo_q);
      end
      ST_CODE: codes_q[sel_q] <= cout;
      ST_FLOAT: fbits_q <= fcomb;
      ST_DONE: if (out_load) begin
        record_valid_o       <= en_item_q;
        elapsed_float_bits_o <= en_item_q ? fbits_q : '0;
        begin_seconds_o      <= en_item_q ? wall_q - quo_q : '0;
        user_time_code_o     <= en_item_q ? codes_q[0] : '0;
        system_time_code_o   <= en_item_q ? codes_q[1] : '0;
        memory_code_o        <= en_item_q ? codes_q[2] : '0;
        minor_fault_code_o   <= en_item_q ? codes_q[3] : '0;
        major_fault_code_o   <= en_item_q ? codes_q[4] : '0;
        record_flags_o       <= en_item_q ? flags_q : '0;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(begin_seconds_o) &&
    $stable(record_flags_o)) else $error("pending result changed");
  a_done_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> out_valid_o) else $error("result not raised");
  a_idle_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ST_IDLE)) else $error("sequencer did not start");
`endif

endmodule
